[hw/rtl/hpv_pkg.sv]
package hpv_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_HALL  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_CPR = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_INV = 1'b1;

  localparam logic [15:0] CprReset = 16'd90;

  // Velocity datapath widths
  localparam int QW      = 10;  // floor(1000/interval) <= 1000
  localparam int ProdW   = 42;  // |delta| * q
  localparam int HalfW   = 21;  // product split for the constant multiply
  localparam int AccW    = 61;  // |delta| * q * 2 * pi_q16 + cpr/2
  localparam int NumW    = 62;  // divider shift register
  localparam int RemW    = 16;
  localparam int QSteps  = QW / 2;    // two quotient bits per cycle
  localparam int NSteps  = NumW / 2;
  localparam int CntW    = $clog2(NSteps + 1);

  localparam logic [QW-1:0] MsPerSec  = 10'd1000;
  // 2 * round(pi * 2^16)
  localparam logic [18:0]   TwoPiQ16  = 19'd411774;

  localparam logic [NumW-1:0] VelPosMax = NumW'(48'h7FFF_FFFF_FFFF);
  localparam logic [NumW-1:0] VelNegMag = NumW'(48'h8000_0000_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QDIV,
    ST_MULQ,
    ST_MULLO,
    ST_MULHI,
    ST_NDIV,
    ST_SAT,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul_q;
    logic mul_lo;
    logic mul_hi;
    logic sat;
    logic push;
  } dp_ctrl_t;

  // Place of a hall code {A,B,C} in the forward sequence 011,001,101,100,110,010;
  // 6 marks invalid.
  function automatic logic [2:0] seq_pos(input logic [2:0] code);
    logic [2:0] p;
    case (code)
      3'd3:    p = 3'd0;
      3'd1:    p = 3'd1;
      3'd5:    p = 3'd2;
      3'd4:    p = 3'd3;
      3'd6:    p = 3'd4;
      3'd2:    p = 3'd5;
      default: p = 3'd6;
    endcase
    return p;
  endfunction

  // Signed step from old code to new code: 01 forward, 11 back, 00 none.
  function automatic logic [1:0] step_of(input logic [2:0] old_code,
                                         input logic [2:0] new_code);
    logic [2:0] np;
    logic [2:0] op;
    logic [2:0] prev_p;
    logic [2:0] next_p;
    logic [1:0] s;
    np     = seq_pos(new_code);
    op     = seq_pos(old_code);
    prev_p = (np == 3'd0) ? 3'd5 : np - 3'd1;
    next_p = (np == 3'd5) ? 3'd0 : np + 3'd1;
    s      = 2'b00;
    if (np != 3'd6 && op != 3'd6) begin
      if (op == prev_p) begin
        s = 2'b01;
      end else if (op == next_p) begin
        s = 2'b11;
      end
    end
    return s;
  endfunction

endpackage

[hw/rtl/hpv_ctrl.sv]
module hpv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hpv_pkg::dp_ctrl_t ctrl_o
);
  import hpv_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_e'(command_i) == CMD_TICK) begin
            state_d = ST_QDIV;
            cnt_d   = CntW'(QSteps - 1);
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_QDIV: begin
        if (cnt_q == '0) state_d = ST_MULQ;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_MULQ:  state_d = ST_MULLO;
      ST_MULLO: state_d = ST_MULHI;
      ST_MULHI: begin
        state_d = ST_NDIV;
        cnt_d   = CntW'(NSteps - 1);
      end
      ST_NDIV: begin
        if (cnt_q == '0) state_d = ST_SAT;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_SAT: state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctrl_o.accept = in_valid_i;
      end
      ST_QDIV:  ctrl_o.div_step = 1'b1;
      ST_MULQ:  ctrl_o.mul_q    = 1'b1;
      ST_MULLO: ctrl_o.mul_lo   = 1'b1;
      ST_MULHI: ctrl_o.mul_hi   = 1'b1;
      ST_NDIV:  ctrl_o.div_step = 1'b1;
      ST_SAT:   ctrl_o.sat      = 1'b1;
      ST_PUSH: begin
        if (out_free) begin
          ctrl_o.push = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ctrl_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/hpv_dp.sv]
module hpv_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hpv_pkg::dp_ctrl_t               ctrl_i,
  input  logic [1:0]                      command_i,
  input  logic                            hall_a_i,
  input  logic                            hall_b_i,
  input  logic                            hall_c_i,
  input  logic [15:0]                     interval_ms_i,
  input  logic                            cfg_wr_en_i,
  input  logic [hpv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hpv_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic signed [31:0]              position_o,
  output logic signed [1:0]               step_dir_o,
  output logic signed [31:0]              count_delta_o,
  output logic signed [47:0]              velocity_q16_o
);
  import hpv_pkg::*;

  // architectural state and configuration
  logic [15:0] cpr_q, cpr_d;
  logic        inv_q, inv_d;
  logic [2:0]  last_code_q, last_code_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] snap_q, snap_d;

  // per-word working registers
  logic [1:0]       w_step_q, w_step_d;
  logic [31:0]      w_delta_q, w_delta_d;
  logic [47:0]      w_vel_q, w_vel_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  acc_q, acc_d;

  // shared restoring divider
  logic [NumW-1:0] div_num_q, div_num_d;
  logic [RemW-1:0] div_rem_q, div_rem_d;
  logic [RemW-1:0] div_den_q, div_den_d;

  // output word
  logic [31:0] out_pos_q;
  logic [1:0]  out_step_q;
  logic [31:0] out_delta_q;
  logic [47:0] out_vel_q;

  logic [15:0]     cpr_eff;
  logic [2:0]      code;
  logic [1:0]      step;
  logic [31:0]     mag;
  logic [AccW-1:0] hi_term;
  logic [NumW-1:0] m_cap;
  logic            out_neg;

  assign cpr_eff = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign code    = {hall_a_i, hall_b_i, hall_c_i};
  assign step    = step_of(last_code_q, code);
  assign mag     = w_delta_q[31] ? (~w_delta_q + 32'd1) : w_delta_q;
  assign hi_term = (AccW'(prod_q[ProdW-1:HalfW]) * AccW'(TwoPiQ16)) << HalfW;
  assign out_neg = w_delta_q[31] ^ inv_q;

  always_comb begin
    if (out_neg) begin
      m_cap = (div_num_q > VelNegMag) ? VelNegMag : div_num_q;
    end else begin
      m_cap = (div_num_q > VelPosMax) ? VelPosMax : div_num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q       <= CprReset;
      inv_q       <= 1'b0;
      last_code_q <= '0;
      pos_q       <= '0;
      snap_q      <= '0;
    end else begin
      cpr_q       <= cpr_d;
      inv_q       <= inv_d;
      last_code_q <= last_code_d;
      pos_q       <= pos_d;
      snap_q      <= snap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_step_q  <= w_step_d;
    w_delta_q <= w_delta_d;
    w_vel_q   <= w_vel_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    if (ctrl_i.push) begin
      out_pos_q   <= pos_q;
      out_step_q  <= w_step_q;
      out_delta_q <= w_delta_q;
      out_vel_q   <= w_vel_q;
    end
  end

  // configuration writes
  always_comb begin
    cpr_d = cpr_q;
    inv_d = inv_q;
    if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        REG_CPR: cpr_d = cfg_data_i;
        REG_INV: inv_d = cfg_data_i[0];
        default: cpr_d = cpr_q;
      endcase
    end
  end

  // word acceptance: counter update and working register load; velocity load on saturate
  always_comb begin
    last_code_d = last_code_q;
    pos_d       = pos_q;
    snap_d      = snap_q;
    w_step_d    = w_step_q;
    w_delta_d   = w_delta_q;
    w_vel_d     = w_vel_q;
    if (ctrl_i.accept) begin
      w_step_d  = '0;
      w_delta_d = '0;
      w_vel_d   = '0;
      case (cmd_e'(command_i))
        CMD_HALL: begin
          w_step_d    = step;
          pos_d       = pos_q + {{30{step[1]}}, step};
          last_code_d = code;
        end
        CMD_TICK: begin
          w_delta_d = pos_q - snap_q;
          snap_d    = pos_q;
        end
        CMD_CLEAR: begin
          pos_d  = '0;
          snap_d = '0;
        end
        default: pos_d = pos_q;
      endcase
    end
    if (ctrl_i.sat) begin
      w_vel_d = out_neg ? (~m_cap[47:0] + 48'd1) : m_cap[47:0];
    end
  end

  // multiply chain
  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctrl_i.mul_q) begin
      prod_d = ProdW'(mag) * ProdW'(div_num_q[QW-1:0]);
    end
    if (ctrl_i.mul_lo) begin
      acc_d = AccW'(prod_q[HalfW-1:0]) * AccW'(TwoPiQ16) + AccW'(cpr_eff >> 1);
    end
  end

  // divider: load, then two quotient bits per step
  always_comb begin
    logic [RemW:0]   r;
    logic [NumW-1:0] n;
    logic [RemW-1:0] rem;
    div_num_d = div_num_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    n         = div_num_q;
    rem       = div_rem_q;
    r         = '0;
    if (ctrl_i.accept) begin
      div_num_d = {MsPerSec, {(NumW-QW){1'b0}}};
      div_rem_d = '0;
      div_den_d = (interval_ms_i == '0) ? 16'd1 : interval_ms_i;
    end else if (ctrl_i.mul_hi) begin
      div_num_d = NumW'(acc_q + hi_term);
      div_rem_d = '0;
      div_den_d = cpr_eff;
    end else if (ctrl_i.div_step) begin
      for (int i = 0; i < 2; i++) begin
        r = {rem, n[NumW-1]};
        n = {n[NumW-2:0], 1'b0};
        if (r >= {1'b0, div_den_q}) begin
          r    = r - {1'b0, div_den_q};
          n[0] = 1'b1;
        end
        rem = r[RemW-1:0];
      end
      div_num_d = n;
      div_rem_d = rem;
    end
  end

  assign position_o     = out_pos_q;
  assign step_dir_o     = out_step_q;
  assign count_delta_o  = out_delta_q;
  assign velocity_q16_o = out_vel_q;

endmodule

[hw/rtl/hall_position_velocity_top.sv]
// Hall position counter with speed estimate. Each input word carries a
// command: a hall sample steps a signed 32-bit position count by +1/-1 when
// the {A,B,C} code moves one place forward/back in the sequence
// 011,001,101,100,110,010 (invalid codes and skips count nothing, the code is
// kept either way); a speed tick reports the count change since the previous
// tick and a Q16.16 rad/s velocity = change * floor(1000/interval_ms) * 2*pi /
// counts_per_rev, rounded, saturated to 48 bits and negated when
// invert_direction is set; a clear zeroes the position and the tick snapshot.
// Every word yields exactly one result word. Hall samples, clears and unused
// codes go from acceptance through the push state into the output register.
// A speed tick divides 1000/interval in one shared restoring divider retiring
// two quotient bits per cycle, multiplies by the quotient and then by 2*pi in
// low and high halves, divides the 62-bit scaled product over counts_per_rev
// in the same divider, saturates and loads the output. One word is in work at
// a time; a new word is taken while the previous result still waits in the
// output register. Config writes are only legal while idle.
module hall_position_velocity_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic                         hall_a_i,
  input  logic                         hall_b_i,
  input  logic                         hall_c_i,
  input  logic [15:0]                  interval_ms_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           position_o,
  output logic signed [1:0]            step_dir_o,
  output logic signed [31:0]           count_delta_o,
  output logic signed [47:0]           velocity_q16_o,
  // register writes: index 0 counts_per_rev, index 1 invert_direction
  input  logic                         cfg_wr_en_i,
  input  logic [hpv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hpv_pkg::CfgDataW-1:0] cfg_data_i
);
  import hpv_pkg::*;

  dp_ctrl_t ctrl;

  // sequencer: accepts words, walks the divide / multiply steps of a speed
  // tick and owns the output valid
  hpv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // counters, config registers, multiplier chain, divider, output word
  hpv_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .command_i      (command_i),
    .hall_a_i       (hall_a_i),
    .hall_b_i       (hall_b_i),
    .hall_c_i       (hall_c_i),
    .interval_ms_i  (interval_ms_i),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .position_o     (position_o),
    .step_dir_o     (step_dir_o),
    .count_delta_o  (count_delta_o),
    .velocity_q16_o (velocity_q16_o)
  );

endmodule

[hw/rtl/hpv_checker.sv]
module hpv_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [31:0]           position_o,
  input logic signed [1:0]            step_dir_o,
  input logic signed [31:0]           count_delta_o,
  input logic signed [47:0]           velocity_q16_o
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) &&
      $stable(count_delta_o) && $stable(velocity_q16_o))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word accepted while previous still in work");

  // a hall step never comes with speed data
  a_step_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_dir_o != 2'sb00 |->
      count_delta_o == 32'sd0 && velocity_q16_o == 48'sd0)
    else $error("step and speed fields both set");

  // no motion, no speed
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_delta_o == 32'sd0 |-> velocity_q16_o == 48'sd0)
    else $error("velocity without count change");

endmodule

bind hall_position_velocity_top hpv_checker u_hpv_checker (.*);

[sim/hall_position_velocity_top_tb.sv]
module hall_position_velocity_top_tb;
  import hpv_pkg::*;

  localparam int unsigned StallHoldCycles = 600;   // long receiver hold-off
  localparam int unsigned WatchdogLimit   = 4000;  // cycles with no word moving
  localparam int unsigned TailCycles      = 64;    // longer than a speed tick takes to get through
  localparam int unsigned RandomPerPhase  = 370;
  localparam int unsigned MaxReported     = 10;

  // one result word as the block reports it
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [1:0]  step_dir;
    logic signed [31:0] count_delta;
    logic signed [47:0] velocity;
  } hall_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          command_i;
  logic                hall_a_i;
  logic                hall_b_i;
  logic                hall_c_i;
  logic [15:0]         interval_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [31:0]  position_o;
  logic signed [1:0]   step_dir_o;
  logic signed [31:0]  count_delta_o;
  logic signed [47:0]  velocity_q16_o;
  logic                cfg_wr_en_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predicted results, oldest first. Filled when a word is accepted,
  // drained by the result checker.
  hall_result_t expected_results[$];

  // Shadow of the block: registers and counter state.
  logic [15:0] cfg_cpr;
  logic        cfg_inv;
  logic [2:0]  last_code;
  logic [31:0] pos_count;
  logic [31:0] tick_snap;

  // Traffic shaping knobs, in percent, and the long hold-off request.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;

  int unsigned mismatches;
  int unsigned walk_place;   // where the stimulus walker sits in the sequence

  hall_position_velocity_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .hall_a_i       (hall_a_i),
    .hall_b_i       (hall_b_i),
    .hall_c_i       (hall_c_i),
    .interval_ms_i  (interval_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .step_dir_o     (step_dir_o),
    .count_delta_o  (count_delta_o),
    .velocity_q16_o (velocity_q16_o),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers. Forward order of the {A,B,C} code is 3,1,5,4,6,2.
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] code_at(input int unsigned place);
    case (place)
      0:       return 3'd3;
      1:       return 3'd1;
      2:       return 3'd5;
      3:       return 3'd4;
      4:       return 3'd6;
      default: return 3'd2;
    endcase
  endfunction

  // 6 means the code is not in the sequence (000 or 111)
  function automatic int unsigned place_of(input logic [2:0] code);
    for (int unsigned p = 0; p < 6; p++) begin
      if (code_at(p) == code) return p;
    end
    return 6;
  endfunction

  // Q16.16 rad/s from a count change: |d| * floor(1000/ms) * 2 * pi / cpr,
  // pi in Q16, rounded, sign from d and the invert bit, saturated to 48 bits.
  function automatic logic [47:0] speed_q16(input logic [31:0] delta,
                                            input logic [15:0] interval);
    logic [31:0] abs_delta;
    logic [63:0] per_sec;
    logic [63:0] cpr;
    logic [63:0] mag;
    logic        negative;
    abs_delta = delta[31] ? -delta : delta;
    per_sec   = 64'd1000 / ((interval == 16'd0) ? 64'd1 : {48'd0, interval});
    cpr       = (cfg_cpr == 16'd0) ? 64'd1 : {48'd0, cfg_cpr};
    mag       = ({32'd0, abs_delta} * per_sec * 64'd2 * 64'd205887 + cpr / 64'd2) / cpr;
    negative  = delta[31] ^ cfg_inv;
    if (mag == 64'd0) return 48'd0;
    if (negative) begin
      if (mag > 64'h8000_0000_0000) mag = 64'h8000_0000_0000;
      mag = -mag;
    end else if (mag > 64'h7FFF_FFFF_FFFF) begin
      mag = 64'h7FFF_FFFF_FFFF;
    end
    return mag[47:0];
  endfunction

  // Advance the shadow state by one accepted word and queue its result.
  task automatic predict_word(input cmd_e cmd, input logic [2:0] code,
                              input logic [15:0] interval);
    hall_result_t r;
    int unsigned  np;
    int unsigned  op;
    int unsigned  hop;
    r = '0;
    case (cmd)
      CMD_HALL: begin
        np = place_of(code);
        op = place_of(last_code);
        if (np != 6 && op != 6) begin
          hop = (np + 6 - op) % 6;
          if (hop == 1) begin
            pos_count  = pos_count + 32'd1;
            r.step_dir = 2'sb01;
          end else if (hop == 5) begin
            pos_count  = pos_count - 32'd1;
            r.step_dir = 2'sb11;
          end
        end
        last_code = code;   // kept even when invalid or skipped
      end
      CMD_TICK: begin
        r.count_delta = pos_count - tick_snap;
        tick_snap     = pos_count;
        r.velocity    = speed_q16(r.count_delta, interval);
      end
      CMD_CLEAR: begin
        pos_count = 32'd0;
        tick_snap = 32'd0;
      end
      default: ;   // unused code: only reports the position
    endcase
    r.position = pos_count;
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Tasks enter and leave on a falling edge; the valid is left high
  // on return so back-to-back words carry no bubble.
  // ---------------------------------------------------------------------------
  task automatic send_word(input cmd_e cmd, input logic [2:0] code,
                           input logic [15:0] interval);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    hall_a_i      <= code[2];
    hall_b_i      <= code[1];
    hall_c_i      <= code[0];
    interval_ms_i <= interval;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(cmd, code, interval);
    @(negedge clk_i);
  endtask

  // Mostly short intervals so the speed is nonzero; some long ones (floor
  // of 1000/ms is zero) and the corners 0, 1 and all ones.
  function automatic logic [15:0] rand_interval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)  return 16'd0;
    if (r < 6)  return 16'hFFFF;
    if (r < 10) return 16'd1;
    if (r < 25) return 16'($urandom_range(20, 1));
    if (r < 75) return 16'($urandom_range(1000, 1));
    return 16'($urandom());
  endfunction

  task automatic send_hall(input logic [2:0] code);
    send_word(CMD_HALL, code, rand_interval());
  endtask

  task automatic send_tick(input logic [15:0] interval);
    send_word(CMD_TICK, 3'($urandom()), interval);
  endtask

  // n clean steps along the sequence
  task automatic walk(input int unsigned n, input bit forward);
    repeat (n) begin
      walk_place = forward ? (walk_place + 1) % 6 : (walk_place + 5) % 6;
      send_hall(code_at(walk_place));
    end
  endtask

  // One random word. Mostly clean steps with a drifting direction so the
  // count moves far enough for useful speeds; the rest is noise, ticks,
  // clears and the unused code.
  bit walk_fwd = 1'b1;
  task automatic random_word();
    int unsigned r;
    logic [2:0]  code;
    r = $urandom_range(99);
    if (r < 58) begin
      if ($urandom_range(99) < 8) walk_fwd = ~walk_fwd;
      walk(1, walk_fwd);
    end else if (r < 66) begin
      code = 3'($urandom());    // invalid codes, skips, repeats
      if (place_of(code) != 6) walk_place = place_of(code);
      send_hall(code);
    end else if (r < 69) begin
      send_hall(code_at(walk_place));
    end else if (r < 91) begin
      send_tick(rand_interval());
    end else if (r < 96) begin
      send_word(CMD_CLEAR, 3'($urandom()), 16'($urandom()));
    end else begin
      send_word(CMD_NOP, 3'($urandom()), 16'($urandom()));
    end
  endtask

  // Drop valid and let every outstanding result drain. Every word yields a
  // result, so an empty queue means the block is idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] cpr, input logic inv);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i   <= REG_CPR;
    cfg_data_i  <= cpr;
    @(negedge clk_i);
    cfg_idx_i   <= REG_INV;
    cfg_data_i  <= {15'd0, inv};
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    cfg_cpr = cpr;
    cfg_inv = inv;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners at reset settings: first sample, full turns both ways, invalid
  // codes, skips, repeats, interval extremes, clear and the unused code.
  task automatic test_directed();
    send_hall(3'b011);            // first sample: stored code 000, no count
    send_hall(3'b001);            // one forward
    walk_place = 1;
    walk(6, 1'b1);                // full turn forward
    send_tick(16'd0);             // zero interval acts as 1 ms
    walk(6, 1'b0);                // full turn back
    walk(2, 1'b0);
    send_tick(16'd1);             // negative delta, fastest interval
    send_hall(3'b000);            // invalid code is stored
    send_hall(3'b001);            // old code invalid: no count
    send_hall(3'b111);            // other invalid code
    send_hall(3'b001);
    send_hall(3'b001);            // same code
    send_hall(3'b110);            // skip of three places
    walk_place = 4;
    walk(3, 1'b1);
    send_tick(16'hFFFF);          // speed rounds to zero
    walk(2, 1'b1);
    send_tick(16'd1000);
    send_word(CMD_CLEAR, 3'b111, 16'hFFFF);
    send_tick(16'd7);             // right after clear: zero delta
    send_word(CMD_NOP, 3'b111, 16'hFFFF);
    send_word(CMD_NOP, 3'b000, 16'h0000);
    walk(1, 1'b1);                // stored code survived the clear
  endtask

  // Register extremes, each with runs both ways and fast ticks.
  task automatic test_register_extremes();
    logic [15:0] cprs [4];
    logic        invs [4];
    cprs = '{16'd1, 16'hFFFF, 16'd0, 16'd6};
    invs = '{1'b1, 1'b0, 1'b1, 1'b0};
    for (int i = 0; i < 4; i++) begin
      wait_idle();
      set_regs(cprs[i], invs[i]);
      walk(9, 1'b1);
      send_tick(16'd1);
      walk(14, 1'b0);
      send_tick(16'd1);
      send_tick(16'd3);           // nothing moved since last tick
      walk(4, 1'b1);
      send_tick(rand_interval());
    end
  endtask

  // Random traffic under each idling mix, new register settings per phase.
  task automatic test_random_traffic();
    int unsigned idle_mix  [4];
    int unsigned stall_mix [4];
    logic [15:0] cpr;
    idle_mix  = '{0, 62, 0, 24};
    stall_mix = '{0, 0, 62, 24};
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       cpr = CprReset;
        1:       cpr = 16'($urandom_range(400, 1));
        2:       cpr = 16'hFFFF;
        default: cpr = 16'($urandom());
      endcase
      set_regs(cpr, ph[0]);
      send_idle_pct = idle_mix[ph];
      stall_pct     = stall_mix[ph];
      repeat (RandomPerPhase) random_word();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_output_hold();
    wait_idle();
    set_regs(16'd12, 1'b0);
    hold_req = 1'b1;
    repeat (40) random_word();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off when asked.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (StallHoldCycles) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    hall_result_t want;
    hall_result_t got;
    if (out_valid_o && !out_stall_i) begin
      got = {position_o, step_dir_o, count_delta_o, velocity_q16_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result word: pos %h step %h delta %h vel %h",
                   got.position, got.step_dir, got.count_delta, got.velocity);
      end else begin
        want = expected_results.pop_front();
        if (got.position !== want.position || got.step_dir !== want.step_dir ||
            got.count_delta !== want.count_delta || got.velocity !== want.velocity) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("mismatch: exp pos %h step %h delta %h vel %h",
                     want.position, want.step_dir, want.count_delta, want.velocity);
            $display("          got pos %h step %h delta %h vel %h",
                     got.position, got.step_dir, got.count_delta, got.velocity);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which work is pending but no word moves.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (!in_valid_i && expected_results.size() == 0)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("hall_position_velocity_top test failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_HALL;
    hall_a_i      = 1'b0;
    hall_b_i      = 1'b0;
    hall_c_i      = 1'b0;
    interval_ms_i = 16'd0;
    cfg_wr_en_i   = 1'b0;
    cfg_idx_i     = REG_CPR;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    mismatches    = 0;
    walk_place    = 0;
    // shadow matches the block's reset state
    cfg_cpr       = CprReset;
    cfg_inv       = 1'b0;
    last_code     = 3'd0;
    pos_count     = 32'd0;
    tick_snap     = 32'd0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_output_hold();

    wait_idle();
    repeat (TailCycles) @(negedge clk_i);   // catch any stray result words
    if (mismatches == 0) begin
      $display("hall_position_velocity_top test passed");
    end else begin
      $display("hall_position_velocity_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/hpv_pkg.sv
hw/rtl/hpv_ctrl.sv
hw/rtl/hpv_dp.sv
hw/rtl/hall_position_velocity_top.sv
hw/rtl/hpv_checker.sv
sim/hall_position_velocity_top_tb.sv
